@@ design/isws_pkg.sv @@
// isws_pkg: shared types and constants for the interval stopwatch
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package isws_pkg;
    localparam int STORE_DEPTH_DEF = 128;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd65481;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_REL   = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_ACC,
        ST_MEAN,
        ST_NUM,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } stat_state_t;
endpackage
`default_nettype wire

@@ design/interval_stopwatch_with_stats.sv @@
// interval_stopwatch_with_stats: top level, phase control, store walk, divide and root
// depends on isws_pkg, isws_ram
//
//  channel | direction | fields
//  in      | request   | command, button_level
//  out     | result    | status .. error_led
//  cfg     | write     | timeout_ticks
//
// ticks and edges other than the final release are handled directly, without a statistics pass
// final release: one store write, reads of the stored entries, a settle state, a 96-step
// divide for the mean, a numerator step, a 96-step divide for the variance, 24 square
// root steps and an output state that presents the result
// reset is asynchronous; the store is not cleared, only entries below the count are read
// in_stall is high while a statistics pass runs or a result waits
`timescale 1ns / 1ps
`default_nettype none
module interval_stopwatch_with_stats
    import isws_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic        button_level,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [15:0]      interval_ticks,
    output logic [23:0]      mean_q8,
    output logic [23:0]      std_dev_q8,
    output logic [7:0]       sample_total,
    output logic             store_full,
    output logic             done_led,
    output logic             error_led
);
    localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int NW = $clog2(STORE_DEPTH + 1);
    localparam int SW = COUNT_WIDTH + NW;          // sum width
    localparam int QW = 2 * COUNT_WIDTH + NW;      // sum of squares width
    localparam int VW = 2 * QW + 16;               // numerator width
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [15:0]            timeout_reg;
    phase_t                 phase_reg;
    logic                   running_reg;
    logic [COUNT_WIDTH-1:0] tick_reg;
    logic                   done_reg, err_reg;
    logic [NW-1:0]          cnt_reg;
    stat_state_t            st_reg, st_next;

    logic [NW-1:0]          idx_reg;
    logic [SW-1:0]          sum_reg;
    logic [QW-1:0]          sq_reg;
    logic [VW-1:0]          rem_reg, quo_reg;
    logic [VW-1:0]          dvd_reg;
    logic [7:0]             step_reg;
    logic                   div_mean_reg;
    logic [47:0]            rad_reg, root_reg, srem_reg;
    logic [COUNT_WIDTH-1:0] iv_reg;
    logic [2*NW-1:0]        nn_reg;

    logic                   ram_we;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   acc_valid_reg;

    logic take;
    assign in_stall = out_valid || (st_reg != ST_IDLE);
    assign take     = in_valid && !in_stall;

    isws_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (iv_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );
    assign ram_we = (st_reg == ST_WRITE) && (cnt_reg < NW'(STORE_DEPTH));

    // divider step: restoring, one bit per cycle
    logic [VW:0]   trial;
    logic [VW-1:0] divisor;
    assign divisor = div_mean_reg ? VW'(cnt_reg) : VW'(nn_reg);
    assign trial   = {rem_reg, dvd_reg[VW-1]} - {1'b0, divisor};

    // root step
    logic [49:0] rtrial;
    assign rtrial = {srem_reg, rad_reg[47:46]} - {root_reg, 2'b01};

    // sequencer next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (take && command && phase_reg == PH_STOP) st_next = ST_WRITE;
            ST_WRITE: st_next = ST_READ;
            ST_READ:  if (idx_reg == cnt_reg) st_next = ST_ACC;
            ST_ACC:   st_next = ST_MEAN;
            ST_MEAN:  if (step_reg == 8'(VW - 1)) st_next = ST_NUM;
            ST_NUM:   st_next = ST_DIV;
            ST_DIV:   if (step_reg == 8'(VW - 1)) st_next = ST_SQRT;
            ST_SQRT:  if (step_reg == 8'd23) st_next = ST_OUT;
            ST_OUT:   st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    logic [VW-1:0] num_full;
    assign num_full = (VW'(sq_reg) * VW'(cnt_reg) - VW'(sum_reg) * VW'(sum_reg)) << 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= PH_IDLE;
            running_reg <= 1'b0;
            tick_reg    <= '0;
            done_reg    <= 1'b0;
            err_reg     <= 1'b0;
            cnt_reg     <= '0;
            st_reg      <= ST_IDLE;
            out_valid   <= 1'b0;
            acc_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we) timeout_reg <= cfg_wdata;
            if (out_valid && !out_stall) out_valid <= 1'b0;
            st_reg <= st_next;
            acc_valid_reg <= (st_reg == ST_READ) && (idx_reg != cnt_reg);
            if (take)
            begin
                if (!command)
                begin
                    if (running_reg)
                    begin
                        if ({{(32-COUNT_WIDTH){1'b0}}, tick_reg} >= {16'd0, timeout_reg}
                            || tick_reg == CMAX)
                        begin
                            running_reg <= 1'b0;
                            tick_reg    <= '0;
                            phase_reg   <= PH_IDLE;
                            if (button_level) err_reg <= 1'b1;
                            out_valid      <= 1'b1;
                            status         <= 1'b1;
                            interval_ticks <= '0;
                            mean_q8        <= '0;
                            std_dev_q8     <= '0;
                            sample_total   <= 8'(cnt_reg);
                            store_full     <= cnt_reg >= NW'(STORE_DEPTH);
                            done_led       <= done_reg;
                            error_led      <= err_reg | button_level;
                        end
                        else
                        begin
                            tick_reg <= tick_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (err_reg) err_reg <= 1'b0;
                            else
                            begin
                                done_reg    <= 1'b0;
                                running_reg <= 1'b1;
                                tick_reg    <= '0;
                                phase_reg   <= PH_PRESS;
                            end
                        end
                        PH_PRESS: phase_reg <= PH_REL;
                        PH_REL:   phase_reg <= PH_STOP;
                        PH_STOP:
                        begin
                            running_reg <= 1'b0;
                            done_reg    <= 1'b1;
                            iv_reg      <= tick_reg;
                            tick_reg    <= '0;
                            phase_reg   <= PH_IDLE;
                        end
                        default: phase_reg <= PH_IDLE;
                    endcase
                end
            end
            if (ram_we) cnt_reg <= cnt_reg + 1'b1;
            if (st_reg == ST_OUT)
            begin
                out_valid      <= 1'b1;
                status         <= 1'b0;
                interval_ticks <= 16'(iv_reg);
                sample_total   <= 8'(cnt_reg);
                store_full     <= cnt_reg >= NW'(STORE_DEPTH);
                done_led       <= done_reg;
                error_led      <= err_reg;
                std_dev_q8     <= (|quo_reg[VW-1:48]) ? SAT24 :
                                  (|root_reg[47:24]) ? SAT24 : root_reg[23:0];
            end
            if (st_reg == ST_NUM)
            begin
                mean_q8 <= (|quo_reg[VW-1:24]) ? SAT24 : quo_reg[23:0];
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_WRITE:
            begin
                idx_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end
            ST_READ:
            begin
                if (idx_reg != cnt_reg) idx_reg <= idx_reg + 1'b1;
                if (acc_valid_reg)
                begin
                    sum_reg <= sum_reg + SW'(ram_rdata);
                    sq_reg  <= sq_reg + QW'(ram_rdata) * QW'(ram_rdata);
                end
                nn_reg <= (2*NW)'(cnt_reg) * (2*NW)'(cnt_reg);
            end
            ST_ACC:
            begin
                if (acc_valid_reg)
                begin
                    sum_reg <= sum_reg + SW'(ram_rdata);
                    sq_reg  <= sq_reg + QW'(ram_rdata) * QW'(ram_rdata);
                end
                // sum is complete here, the last read landed in the final read cycle
                div_mean_reg <= 1'b1;
                dvd_reg  <= VW'(sum_reg) << 8;
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_MEAN, ST_DIV:
            begin
                step_reg <= step_reg + 1'b1;
                dvd_reg  <= dvd_reg << 1;
                if (!trial[VW])
                begin
                    rem_reg <= trial[VW-1:0];
                    quo_reg <= {quo_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[VW-2:0], dvd_reg[VW-1]};
                    quo_reg <= {quo_reg[VW-2:0], 1'b0};
                end
                if (st_reg == ST_DIV && step_reg == 8'(VW - 1))
                begin
                    step_reg <= '0;
                    root_reg <= '0;
                    srem_reg <= '0;
                    rad_reg  <= !trial[VW] ? {quo_reg[46:0], 1'b1} : {quo_reg[46:0], 1'b0};
                end
                if (st_reg == ST_MEAN && step_reg == 8'(VW - 1)) step_reg <= '0;
            end
            ST_NUM:
            begin
                div_mean_reg <= 1'b0;
                dvd_reg  <= num_full;
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_SQRT:
            begin
                step_reg <= step_reg + 1'b1;
                rad_reg  <= rad_reg << 2;
                if (!rtrial[49])
                begin
                    srem_reg <= rtrial[47:0];
                    root_reg <= {root_reg[46:0], 1'b1};
                end
                else
                begin
                    srem_reg <= {srem_reg[45:0], rad_reg[47:46]};
                    root_reg <= {root_reg[46:0], 1'b0};
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ design/isws_ram.sv @@
// isws_ram: generic single-port-write, registered-read memory
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module isws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/isws_checker.sv @@
// isws_checker: port-level checks for the stopwatch, bound to the top level
// depends on interval_stopwatch_with_stats
`timescale 1ns / 1ps
`default_nettype none
module isws_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic status,
    input wire logic done_led,
    input wire logic [7:0] sample_total
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_total))
        else $error("result dropped while stalled");
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> done_led)
        else $error("completed result without done led");
endmodule
bind interval_stopwatch_with_stats isws_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .done_led(done_led),
    .sample_total(sample_total)
);
`default_nettype wire
